>>> rtl/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// Used by cbm_regs, cbm_decode and the cartridge_bank_mapper top level.
package cbm_pkg;

    // Where one CPU access ends up
    typedef enum logic [2:0] {
        TGT_NONE  = 3'd0,
        TGT_CPUOB = 3'd1,
        TGT_VIDOB = 3'd2,
        TGT_RAM   = 3'd3,
        TGT_FLASH = 3'd4,
        TGT_REG   = 3'd5
    } target_t;

    localparam int AddrWidth    = 16;
    localparam int DataWidth    = 8;
    localparam int MemAddrWidth = 22;
    localparam int OfsWidth     = 13;

    // Control register layout
    localparam int CtrlLockBit  = 7;
    localparam int CtrlWpBit    = 6;
    localparam int CtrlRam5Bit  = 5;
    localparam int CtrlEnHi     = 4;
    localparam int CtrlEnLo     = 3;
    localparam int CtrlA21Bit   = 0;

    localparam logic [1:0] EnRam123 = 2'b01;
    localparam logic [1:0] EnBlk1   = 2'b11;

    localparam logic [DataWidth-1:0]    CtrlResetVal  = 8'h40;
    localparam logic [DataWidth-1:0]    CtrlWriteMask = 8'hF9;
    localparam logic [MemAddrWidth-1:0] Ram123Base    = 22'h002000;

    // Register write request from the decoder
    typedef struct packed {
        logic                 bank_we;
        logic                 ctrl_we;
        logic [DataWidth-1:0] data;
    } reg_wr_t;

    // One decoded result transaction
    typedef struct packed {
        target_t                 target;
        logic [MemAddrWidth-1:0] mem_address;
        logic                    mem_write;
        logic [DataWidth-1:0]    reg_data;
        logic                    io_valid;
    } result_t;

endpackage

>>> rtl/cbm_regs.sv
// Bank select and control registers of the mapper.
// Depends on cbm_pkg; written by requests from cbm_decode.
module cbm_regs
    import cbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 commit,   // the decoded transaction moves on
    input  reg_wr_t              wr,
    output logic [DataWidth-1:0] bank_select,
    output logic [DataWidth-1:0] control_bits
);

    logic [DataWidth-1:0] bank_reg, bank_next;
    logic [DataWidth-1:0] ctrl_reg, ctrl_next;

    always_comb begin
        bank_next = bank_reg;
        ctrl_next = ctrl_reg;
        if (commit && wr.bank_we) begin
            bank_next = wr.data;
        end
        if (commit && wr.ctrl_we) begin
            ctrl_next = wr.data & CtrlWriteMask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg <= '0;
            ctrl_reg <= CtrlResetVal;
        end else begin
            bank_reg <= bank_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign bank_select  = bank_reg;
    assign control_bits = ctrl_reg;

`ifndef ASSERT_OFF
    // Masked bits never become set
    a_ctrl_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg & ~CtrlWriteMask) == '0)
        else $error("control register holds masked bits");

    // A locked window freezes both registers until reset
    a_lock_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg[CtrlLockBit] |=> $stable(bank_reg) && $stable(ctrl_reg))
        else $error("register changed while locked");

    // Never a write to both registers at once
    a_one_we: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.bank_we && wr.ctrl_we))
        else $error("bank and control written together");
`endif

endmodule

>>> rtl/cbm_decode.sv
// Address decode for one CPU access: target, mapped address, register access.
// Depends on cbm_pkg; purely combinational.
module cbm_decode
    import cbm_pkg::*;
(
    input  logic                 wr_cmd,
    input  logic [AddrWidth-1:0] addr,
    input  logic [DataWidth-1:0] wdata,
    input  logic [DataWidth-1:0] bank_select,
    input  logic [DataWidth-1:0] control_bits,
    output result_t              result,
    output reg_wr_t              reg_wr
);

    logic [1:0] en;
    logic       in_ram123, in_blk1, in_blk23, in_blk5, in_io;

    assign en        = control_bits[CtrlEnHi:CtrlEnLo];
    assign in_ram123 = (addr[15:12] == 4'h0) && (addr[11:10] != 2'b00);
    assign in_blk1   = (addr[15:13] == 3'b001);
    assign in_blk23  = (addr[15:14] == 2'b01);
    assign in_blk5   = (addr[15:13] == 3'b101);
    assign in_io     = (addr[15:10] == 6'b100110);

    always_comb begin
        result        = '0;
        result.target = TGT_NONE;
        reg_wr        = '0;
        reg_wr.data   = wdata;

        priority if (in_ram123) begin
            if (en == EnRam123) begin
                result.target      = TGT_RAM;
                result.mem_address = MemAddrWidth'(addr) + Ram123Base;
            end else if (!wr_cmd) begin
                result.target = TGT_VIDOB;
            end
        end else if (in_blk1) begin
            if (en == EnBlk1) begin
                result.target      = TGT_RAM;
                result.mem_address = MemAddrWidth'(addr);
            end else if (!wr_cmd) begin
                result.target = TGT_CPUOB;
            end
        end else if (in_blk23) begin
            result.target      = TGT_RAM;
            result.mem_address = MemAddrWidth'(addr);
        end else if (in_blk5) begin
            if (wr_cmd && control_bits[CtrlWpBit]) begin
                result.target = TGT_NONE;
            end else if (control_bits[CtrlRam5Bit]) begin
                result.target      = TGT_RAM;
                result.mem_address = MemAddrWidth'(addr[OfsWidth-1:0]);
            end else begin
                result.target      = TGT_FLASH;
                result.mem_address = {control_bits[CtrlA21Bit], bank_select,
                                      addr[OfsWidth-1:0]};
            end
        end else if (in_io) begin
            if (control_bits[CtrlLockBit]) begin
                result.target = wr_cmd ? TGT_NONE : TGT_CPUOB;
            end else if (wr_cmd) begin
                result.target  = TGT_REG;
                reg_wr.ctrl_we = addr[0];
                reg_wr.bank_we = !addr[0];
            end else begin
                result.target   = TGT_REG;
                result.reg_data = addr[0] ? control_bits : bank_select;
                result.io_valid = 1'b1;
            end
        end else begin
            result.target = TGT_NONE;
        end

        result.mem_write = wr_cmd &&
            ((result.target == TGT_RAM) || (result.target == TGT_FLASH));
    end

endmodule

>>> rtl/cartridge_bank_mapper.sv
// An accepted s_ transaction passes the input and result registers to reach m_.
// Throughput: one transaction per cycle; s_tready drops only when both the
// input and result registers are full and m_tready is low.
// Register writes take effect for the very next transaction.
// Reset (aresetn low, synchronous): pipeline empty, bank select 0x00,
// control 0x40 (BLK5 write protected, window unlocked).
module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input CPU access channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] cpu_address, [23:16] write_data
    input  logic        s_tuser,   // [0] command (1 = write)
    // Decoded result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [21:0] mem_address, [22] mem_write,
                                   // [30:23] reg_data, [31] io_valid
    output logic [2:0]  m_tuser    // [2:0] target
);

    // Input register stage
    logic                 in_valid_reg, in_valid_next;
    logic                 cmd_reg;
    logic [AddrWidth-1:0] addr_reg;
    logic [DataWidth-1:0] data_reg;

    // Result register stage
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    logic                 out_adv;   // result register may load
    logic                 commit;    // input item moves into the result register
    result_t              dec_result;
    reg_wr_t              dec_wr;
    logic [DataWidth-1:0] bank_select, control_bits;

    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign commit   = in_valid_reg && out_adv;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (out_adv) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_tdata[15:0];
            data_reg <= s_tdata[23:16];
        end
        if (commit) begin
            res_reg <= dec_result;
        end
    end

    // Decode works on the input register against the current mapper state
    cbm_decode u_decode (
        .wr_cmd       (cmd_reg),
        .addr         (addr_reg),
        .wdata        (data_reg),
        .bank_select  (bank_select),
        .control_bits (control_bits),
        .result       (dec_result),
        .reg_wr       (dec_wr)
    );

    // State updates land together with the result register load
    cbm_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .commit       (commit),
        .wr           (dec_wr),
        .bank_select  (bank_select),
        .control_bits (control_bits)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.target;
    assign m_tdata  = {res_reg.io_valid, res_reg.reg_data, res_reg.mem_write,
                       res_reg.mem_address};

`ifndef ASSERT_OFF
    // mem_write only for a RAM or flash transaction
    a_memwr_tgt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.mem_write |->
            (res_reg.target == TGT_RAM) || (res_reg.target == TGT_FLASH))
        else $error("mem_write on non-memory target");

    // io_valid only with a register target
    a_io_tgt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.io_valid |-> (res_reg.target == TGT_REG))
        else $error("io_valid without register target");

    // Input side stalls only when both stages are full and the sink is stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("unexpected input stall");
`endif

endmodule

>>> verif/cbm_scoreboard_pkg.sv
// Scoreboard for the cartridge bank mapper testbench: keeps its own copy of the
// bank and control registers, decodes each accepted access and checks results.
// Depends on cbm_pkg for target codes, widths and the control register layout.
package cbm_scoreboard_pkg;
    import cbm_pkg::*;

    // CPU address windows
    localparam logic [AddrWidth-1:0] Ram123Lo = 16'h0400;
    localparam logic [AddrWidth-1:0] Ram123Hi = 16'h0FFF;
    localparam logic [AddrWidth-1:0] Blk1Lo   = 16'h2000;
    localparam logic [AddrWidth-1:0] Blk1Hi   = 16'h3FFF;
    localparam logic [AddrWidth-1:0] Blk23Lo  = 16'h4000;
    localparam logic [AddrWidth-1:0] Blk23Hi  = 16'h7FFF;
    localparam logic [AddrWidth-1:0] IoWinLo  = 16'h9800;
    localparam logic [AddrWidth-1:0] IoWinHi  = 16'h9BFF;
    localparam logic [AddrWidth-1:0] Blk5Lo   = 16'hA000;
    localparam logic [AddrWidth-1:0] Blk5Hi   = 16'hBFFF;

    localparam int ReportLimit = 10;

    class mapper_scoreboard;
        logic [DataWidth-1:0] bank_sel;
        logic [DataWidth-1:0] ctrl;
        result_t              decoded_q[$];
        int                   errors;

        function new();
            bank_sel = '0;
            ctrl     = CtrlResetVal;
            errors   = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        // Counts a failure; tells the caller whether it should still be printed
        function bit count_error();
            errors++;
            return errors <= ReportLimit;
        endfunction

        // Decode one accepted access against the current register copies
        function void note_access(logic wr, logic [AddrWidth-1:0] addr,
                                  logic [DataWidth-1:0] data);
            result_t    res;
            logic [1:0] en;
            logic [8:0] fbank;
            res   = '0;
            en    = ctrl[CtrlEnHi:CtrlEnLo];
            fbank = {ctrl[CtrlA21Bit], bank_sel};
            if (addr >= Ram123Lo && addr <= Ram123Hi) begin
                if (en == EnRam123) begin
                    res.target      = TGT_RAM;
                    res.mem_address = MemAddrWidth'(addr[OfsWidth-1:0]) + Ram123Base;
                end else if (!wr) begin
                    res.target = TGT_VIDOB;
                end
            end else if (addr >= Blk1Lo && addr <= Blk1Hi) begin
                if (en == EnBlk1) begin
                    res.target      = TGT_RAM;
                    res.mem_address = MemAddrWidth'(addr);
                end else if (!wr) begin
                    res.target = TGT_CPUOB;
                end
            end else if (addr >= Blk23Lo && addr <= Blk23Hi) begin
                res.target      = TGT_RAM;
                res.mem_address = MemAddrWidth'(addr);
            end else if (addr >= Blk5Lo && addr <= Blk5Hi) begin
                // write protect drops RAM and flash writes alike
                if (!(wr && ctrl[CtrlWpBit])) begin
                    if (ctrl[CtrlRam5Bit]) begin
                        res.target      = TGT_RAM;
                        res.mem_address = MemAddrWidth'(addr[OfsWidth-1:0]);
                    end else begin
                        res.target      = TGT_FLASH;
                        res.mem_address = {fbank, addr[OfsWidth-1:0]};
                    end
                end
            end else if (addr >= IoWinLo && addr <= IoWinHi) begin
                if (ctrl[CtrlLockBit]) begin
                    if (!wr) res.target = TGT_CPUOB;
                end else if (wr) begin
                    res.target = TGT_REG;
                    if (addr[0]) ctrl = data & CtrlWriteMask;
                    else bank_sel = data;
                end else begin
                    res.target   = TGT_REG;
                    res.reg_data = addr[0] ? ctrl : bank_sel;
                    res.io_valid = 1'b1;
                end
            end
            res.mem_write = wr && (res.target == TGT_RAM || res.target == TGT_FLASH);
            decoded_q.push_back(res);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got && count_error())
                $display("MISMATCH %s: expected 0x%0h, got 0x%0h", name, want, got);
        endfunction

        // m_tdata: [21:0] mem_address, [22] mem_write, [30:23] reg_data, [31] io_valid
        function void check_result(logic [2:0] tuser, logic [31:0] tdata);
            result_t want;
            if (decoded_q.size() == 0) begin
                if (count_error())
                    $display("MISMATCH unexpected result: target %0d, data 0x%08h",
                             tuser, tdata);
                return;
            end
            want = decoded_q.pop_front();
            check_field("target",      want.target,      tuser);
            check_field("mem_address", want.mem_address, tdata[21:0]);
            check_field("mem_write",   want.mem_write,   tdata[22]);
            check_field("reg_data",    want.reg_data,    tdata[30:23]);
            check_field("io_valid",    want.io_valid,    tdata[31]);
        endfunction
    endclass

endpackage

>>> verif/tb.sv
// Top-level testbench for cartridge_bank_mapper: drives CPU accesses on the s_
// stream, with random gaps and back-pressure, and checks every m_ transaction.
// Depends on cbm_pkg, cbm_scoreboard_pkg and the cartridge_bank_mapper RTL.
module tb;
    import cbm_pkg::*;
    import cbm_scoreboard_pkg::*;

    localparam int RandomAccesses = 850;
    localparam int LockedAccesses = 40;
    localparam int IdlePercent    = 32;
    localparam int SteadyFirst    = 350;    // random accesses run without any idling
    localparam int SteadyLast     = 520;
    localparam int WatchdogLimit  = 2000;   // cycles with no transaction on either side
    localparam int DrainCycles    = 4;
    localparam int ResetCycles    = 7;

    localparam logic CmdRead  = 1'b0;
    localparam logic CmdWrite = 1'b1;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // [15:0] cpu_address, [23:16] write_data
    logic        s_tuser  = 1'b0;   // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [21:0] mem_address, [22] mem_write,
                                    // [30:23] reg_data, [31] io_valid
    logic [2:0]  m_tuser;           // [2:0] target

    logic        steady      = 1'b0;  // both sides stop idling while set
    int          idle_cycles = 0;
    mapper_scoreboard sb;

    // Window borders and their neighbors, hit often by the random part
    logic [AddrWidth-1:0] boundary_addrs [0:17] = '{
        16'h0000, 16'h03FF, 16'h0400, 16'h0FFF, 16'h1000, 16'h1FFF,
        16'h2000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'h97FF,
        16'h9C00, 16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000, 16'hFFFF
    };

    cartridge_bank_mapper dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side back-pressure: ready drops in about a third of the cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= IdlePercent);
        end
    end

    // Monitor: values read at the edge are the pre-edge ones, so a handshake
    // seen here completed at this very edge. A result never leaves at the edge
    // that accepts its own access, so the order of the two calls is harmless.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_access(s_tuser, s_tdata[15:0], s_tdata[23:16]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
        end
    end

    // Watchdog on transaction-free cycles
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one access after an optional random gap; returns at the edge
    // that accepted it, with s_tvalid still high.
    task automatic send_access(input logic wr, input logic [AddrWidth-1:0] addr,
                               input logic [DataWidth-1:0] data);
        while (!steady && $urandom_range(0, 99) < IdlePercent) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= wr;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending until every decoded result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    function automatic logic [AddrWidth-1:0] window_address();
        return IoWinLo + AddrWidth'($urandom_range(0, 16'h03FF));
    endfunction

    function automatic logic [AddrWidth-1:0] pick_address();
        case ($urandom_range(0, 6))
            0:       return AddrWidth'($urandom_range(Ram123Lo, Ram123Hi));
            1:       return AddrWidth'($urandom_range(Blk1Lo, Blk1Hi));
            2:       return AddrWidth'($urandom_range(Blk23Lo, Blk23Hi));
            3:       return AddrWidth'($urandom_range(Blk5Lo, Blk5Hi));
            4:       return window_address();
            5:       return boundary_addrs[$urandom_range(0, 17)];
            default: return AddrWidth'($urandom);
        endcase
    endfunction

    // One access per call, mostly random, else register setup. Unless locking is
    // allowed, control writes keep the lock bit clear so the window stays open.
    task automatic send_random(input bit may_lock);
        logic                 wr;
        logic [AddrWidth-1:0] addr;
        logic [DataWidth-1:0] data;
        int unsigned          pick;
        pick = $urandom_range(0, 99);
        data = DataWidth'($urandom);
        if (pick < 8) begin
            wr      = CmdWrite;              // bank select
            addr    = window_address();
            addr[0] = 1'b0;
        end else if (pick < 16) begin
            wr      = CmdWrite;              // control register
            addr    = window_address();
            addr[0] = 1'b1;
        end else if (pick < 22) begin
            wr   = CmdRead;                  // register readback
            addr = window_address();
        end else begin
            wr   = 1'($urandom_range(0, 1));
            addr = pick_address();
        end
        if (!may_lock && wr && addr >= IoWinLo && addr <= IoWinHi && addr[0])
            data[CtrlLockBit] = 1'b0;
        send_access(wr, addr, data);
    endtask

    initial begin
        sb = new();
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset state: bank 0x00, control 0x40, RAM123 and BLK1 off, BLK5 protected
        send_access(CmdRead,  16'h9800, 8'hFF);
        send_access(CmdRead,  16'h9801, 8'h00);
        send_access(CmdRead,  16'h0400, 8'h00);   // RAM123 off: video open bus
        send_access(CmdWrite, 16'h0FFF, 8'hFF);   // RAM123 off: dropped
        send_access(CmdRead,  16'h2000, 8'h00);   // BLK1 off: cpu open bus
        send_access(CmdWrite, 16'h3FFF, 8'h5A);   // BLK1 off: dropped
        send_access(CmdRead,  16'h4000, 8'h00);
        send_access(CmdWrite, 16'h7FFF, 8'hA5);
        send_access(CmdWrite, 16'hA000, 8'h11);   // write protected
        send_access(CmdRead,  16'hBFFF, 8'h00);   // flash, bank 0
        send_access(CmdRead,  16'h0000, 8'h00);   // unmapped
        send_access(CmdWrite, 16'hFFFF, 8'hFF);
        send_access(CmdRead,  16'h9C00, 8'h00);
        send_access(CmdRead,  16'h97FF, 8'h00);
        // Full bank, control 0x7F stores 0x79: WP, RAM at BLK5, BLK1 on, A21
        send_access(CmdWrite, 16'h9BFE, 8'hFF);
        send_access(CmdWrite, 16'h9801, 8'h7F);
        send_access(CmdRead,  16'h9BFF, 8'h00);
        send_access(CmdWrite, 16'h3FFF, 8'h3C);
        send_access(CmdRead,  16'h0400, 8'h00);   // enable field is BLK1, not RAM123
        send_access(CmdWrite, 16'hA000, 8'h77);   // still protected with RAM at BLK5
        send_access(CmdRead,  16'hBFFF, 8'h00);
        // RAM123 on, no write protect, flash with top bank
        send_access(CmdWrite, 16'h9801, 8'h09);
        send_access(CmdWrite, 16'h0FFF, 8'hC3);
        send_access(CmdWrite, 16'hBFFF, 8'h81);   // flash address 0x3FFFFF
        send_access(CmdRead,  16'h2000, 8'h00);

        drain();

        for (int i = 0; i < RandomAccesses; i++) begin
            steady <= (i >= SteadyFirst && i <= SteadyLast);
            send_random(1'b0);
        end

        // Lock the window for the rest of the run
        drain();
        steady <= 1'b0;
        send_access(CmdWrite, 16'h9BFF, 8'h80 | DataWidth'($urandom));
        send_access(CmdRead,  16'h9800, 8'h00);
        send_access(CmdWrite, 16'h9801, 8'h08);
        send_access(CmdRead,  16'h9BFF, 8'h00);
        for (int i = 0; i < LockedAccesses; i++)
            send_random(1'b1);

        drain();
        repeat (DrainCycles) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
